// ===== design/assert_macros.svh =====
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked at every clock edge outside reset.
`define CRBC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define CRBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define CRBC_ASSERT(lbl, clk, rstn, prop, msg)
`define CRBC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== design/crbc_pkg.sv =====
// Types, codes and defaults of the closable byte ring channel.
package crbc_pkg;

  localparam int unsigned RING_DEPTH_DEF   = 256;
  localparam int unsigned ACCESS_BYTES_DEF = 8;

  localparam int unsigned CAP_W      = 9;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned COUNT_W    = 4;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned BYTE_IDX_W = $clog2(DATA_W / 8);

  typedef logic [CAP_W-1:0]    cap_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [DATA_W-1:0]   data_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cap_t CAP_RESET = 9'd256;

  localparam op_t OP_WRITE = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_CLOSE = 2'd2;

  localparam status_t STS_DONE         = 3'd0;
  localparam status_t STS_WOULD_BLOCK  = 3'd1;
  localparam status_t STS_WRITE_CLOSED = 3'd2;
  localparam status_t STS_READ_CLOSED  = 3'd3;
  localparam status_t STS_TOO_LARGE    = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WRITE,
    S_READ,
    S_DRAIN,
    S_FINISH
  } state_e;

endpackage

// ===== design/crbc_if.sv =====
// Request and result channel interfaces of the closable byte ring channel.
interface crbc_in_if import crbc_pkg::*; ();
  logic   valid;
  logic   ready;
  op_t    op;
  count_t byte_count;
  data_t  write_data;

  modport source (output valid, output op, output byte_count, output write_data,
                  input ready);
  modport sink (input valid, input op, input byte_count, input write_data,
                output ready);
endinterface

interface crbc_out_if import crbc_pkg::*; ();
  logic    valid;
  logic    ready;
  status_t status;
  data_t   read_data;
  logic    read_ok_flag;
  cap_t    fill_level;

  modport source (output valid, output status, output read_data, output read_ok_flag,
                  output fill_level, input ready);
  modport sink (input valid, input status, input read_data, input read_ok_flag,
                input fill_level, output ready);
endinterface

// ===== design/crbc_ram.sv =====
// Generic RAM with one write port and one registered read port.
module crbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== design/closable_byte_ring_channel.sv =====
// Top level of the closable byte ring channel.
//
// A bounded byte channel kept in a ring RAM of RING_DEPTH bytes. Each request word is a
// write, a read or a close of up to ACCESS_BYTES bytes, first byte in the low eight bits;
// each request gives exactly one result word with a status, the read bytes, the sticky
// read-ok flag and the fill after the request. The ring RAM moves one byte per cycle. A
// request is latched when accepted, then evaluated; a write that is done moves its bytes
// into the RAM and a read that is done moves them out and then drains the last RAM byte;
// last the result register is loaded and the next request can be accepted after that.
// One request is in work at a time; a result that waits in the output register stalls
// only the completion of the next request. Writing the capacity register empties the
// ring at once and keeps the closed and read-ok marks; it must be written while no
// request is in work. No clearing pass runs after reset.
`include "assert_macros.svh"

module closable_byte_ring_channel import crbc_pkg::*; #(
  parameter int unsigned RING_DEPTH   = RING_DEPTH_DEF,
  parameter int unsigned ACCESS_BYTES = ACCESS_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  cap_t       cfg_wdata_i,
  crbc_in_if.sink    in_i,
  crbc_out_if.source out_o
);

  localparam int unsigned AW    = $clog2(RING_DEPTH);
  localparam int unsigned CMP_W = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;

  state_e state_q, state_d;

  cap_t            cap_q;
  cap_t            eff_cap;
  logic [AW-1:0]   rpos_q, wpos_q;
  cap_t            held_q;
  logic            closed_q;
  logic            read_ok_q;

  op_t                   op_q;
  count_t                count_q;
  data_t                 wdata_q;
  logic [BYTE_IDX_W-1:0] idx_q, ridx_q;
  logic                  rvld_q;
  data_t                 rdata_q;
  status_t               status_q;

  logic    ovalid_q;
  status_t ostatus_q;
  data_t   ordata_q;
  logic    orok_q;
  cap_t    ofill_q;

  logic       in_ready;
  logic       ram_we;
  logic       out_load;
  logic [7:0] ram_rdata;

  logic    too_big, no_room, too_short, nonzero, last_byte;
  status_t ev_status;
  logic    ev_write, ev_read;

  // Next ring position; positions stay below the effective capacity.
  function automatic logic [AW-1:0] pos_next(input logic [AW-1:0] pos, input cap_t cap);
    logic [CMP_W-1:0] inc;
    inc = CMP_W'(pos) + CMP_W'(1);
    if (inc == CMP_W'(cap)) begin
      return '0;
    end
    return AW'(inc);
  endfunction

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CAP_W'(1);
    end else if (32'(cap_q) > RING_DEPTH) begin
      eff_cap = CAP_W'(RING_DEPTH);
    end else begin
      eff_cap = cap_q;
    end
  end

  // Decision on the latched request, taken in the evaluation cycle.
  always_comb begin
    too_big   = (32'(count_q) > ACCESS_BYTES) || (CAP_W'(count_q) > eff_cap);
    no_room   = ({1'b0, held_q} + (CAP_W + 1)'(count_q)) > {1'b0, eff_cap};
    too_short = held_q < CAP_W'(count_q);
    nonzero   = count_q != '0;
    ev_status = STS_DONE;
    ev_write  = 1'b0;
    ev_read   = 1'b0;
    unique case (op_q)
      OP_WRITE: begin
        if (closed_q) begin
          ev_status = STS_WRITE_CLOSED;
        end else if (too_big) begin
          ev_status = STS_TOO_LARGE;
        end else if (no_room) begin
          ev_status = STS_WOULD_BLOCK;
        end else begin
          ev_write = nonzero;
        end
      end
      OP_READ: begin
        if (too_big) begin
          ev_status = STS_TOO_LARGE;
        end else if (too_short) begin
          ev_status = closed_q ? STS_READ_CLOSED : STS_WOULD_BLOCK;
        end else begin
          ev_read = nonzero;
        end
      end
      default: begin
      end
    endcase
  end

  assign last_byte = (COUNT_W'(idx_q) + COUNT_W'(1)) == count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    in_ready = 1'b0;
    ram_we   = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (ev_write) begin
          state_d = S_WRITE;
        end else if (ev_read) begin
          state_d = S_READ;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
        if (last_byte) begin
          state_d = S_FINISH;
        end
      end
      S_READ: begin
        if (last_byte) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!ovalid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      rpos_q    <= '0;
      wpos_q    <= '0;
      held_q    <= '0;
      closed_q  <= 1'b0;
      read_ok_q <= 1'b1;
      rvld_q    <= 1'b0;
      ovalid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q  <= cfg_wdata_i;
        rpos_q <= '0;
        wpos_q <= '0;
        held_q <= '0;
      end else begin
        if (state_q == S_EVAL) begin
          if (op_q == OP_CLOSE) begin
            closed_q <= 1'b1;
          end
          if (ev_status == STS_READ_CLOSED) begin
            read_ok_q <= 1'b0;
          end
        end
        if (state_q == S_WRITE) begin
          wpos_q <= pos_next(wpos_q, eff_cap);
          if (last_byte) begin
            held_q <= held_q + CAP_W'(count_q);
          end
        end
        if (state_q == S_READ) begin
          rpos_q <= pos_next(rpos_q, eff_cap);
          if (last_byte) begin
            held_q <= held_q - CAP_W'(count_q);
          end
        end
      end
      rvld_q <= state_q == S_READ;
      if (out_load) begin
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      op_q    <= in_i.op;
      count_q <= in_i.byte_count;
      wdata_q <= in_i.write_data;
    end
    if (state_q == S_EVAL) begin
      idx_q    <= '0;
      rdata_q  <= '0;
      status_q <= ev_status;
    end
    if (state_q == S_WRITE) begin
      idx_q   <= idx_q + BYTE_IDX_W'(1);
      wdata_q <= wdata_q >> 8;
    end
    if (state_q == S_READ) begin
      idx_q  <= idx_q + BYTE_IDX_W'(1);
      ridx_q <= idx_q;
    end
    // RAM data of the byte issued in the previous cycle lands at its place in the word.
    if (rvld_q) begin
      rdata_q[{ridx_q, 3'b000} +: 8] <= ram_rdata;
    end
    if (out_load) begin
      ostatus_q <= status_q;
      ordata_q  <= rdata_q;
      orok_q    <= read_ok_q;
      ofill_q   <= held_q;
    end
  end

  crbc_ram #(
    .WIDTH (8),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wpos_q),
    .wdata_i (wdata_q[7:0]),
    .raddr_i (rpos_q),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = ovalid_q;
  assign out_o.status       = ostatus_q;
  assign out_o.read_data    = ordata_q;
  assign out_o.read_ok_flag = orok_q;
  assign out_o.fill_level   = ofill_q;

  `CRBC_ASSERT_ALWAYS(a_held_in_cap, clk_i, held_q <= eff_cap, "fill exceeds capacity")
  `CRBC_ASSERT(a_closed_sticky, clk_i, rst_ni, !$fell(closed_q), "channel reopened")
  `CRBC_ASSERT(a_read_ok_sticky, clk_i, rst_ni, !$rose(read_ok_q), "read-ok flag set again")
  `CRBC_ASSERT(a_result_from_finish, clk_i, rst_ni, $rose(ovalid_q) |-> $past(state_q) == S_FINISH, "result word without finished request")

endmodule

// ===== test/tb.sv =====
// Testbench of the closable byte ring channel: random and directed requests, predicted replies.
`timescale 1ns / 100ps

module tb import crbc_pkg::*; ();

  localparam op_t OP_UNUSED    = 2'd3;
  localparam int  IDLE_LIMIT   = 3000;
  localparam int  HOLD_CYCLES  = 300;
  localparam int  SETTLE_DELAY = 20;
  localparam int  PRINT_LIMIT  = 40;

  typedef struct {
    status_t status;
    data_t   read_data;
    logic    read_ok;
    cap_t    fill;
  } reply_t;

  // Keeps its own copy of the channel and queues the reply each request should give.
  class ring_channel_checker;
    bit [7:0]    ring [RING_DEPTH_DEF];
    int unsigned rd_pos;
    int unsigned wr_pos;
    int unsigned held;
    bit          closed;
    bit          read_ok;
    cap_t        capacity;
    reply_t      pending_replies[$];
    int          errors;

    function new();
      rd_pos   = 0;
      wr_pos   = 0;
      held     = 0;
      closed   = 1'b0;
      read_ok  = 1'b1;
      capacity = CAP_RESET;
      errors   = 0;
    endfunction

    function int unsigned eff_capacity();
      if (capacity == 0) return 1;
      if (capacity > RING_DEPTH_DEF) return RING_DEPTH_DEF;
      return capacity;
    endfunction

    // A capacity write empties the ring but keeps the closed and read-ok marks.
    function void set_capacity(cap_t value);
      capacity = value;
      rd_pos   = 0;
      wr_pos   = 0;
      held     = 0;
    endfunction

    function void accept_request(op_t op, count_t cnt, data_t wdata);
      reply_t      r;
      int unsigned cap;
      int unsigned i;
      r.status    = STS_DONE;
      r.read_data = '0;
      cap = eff_capacity();
      case (op)
        OP_WRITE: begin
          if (closed) begin
            r.status = STS_WRITE_CLOSED;
          end else if (cnt > ACCESS_BYTES_DEF || cnt > cap) begin
            r.status = STS_TOO_LARGE;
          end else if (held + cnt > cap) begin
            r.status = STS_WOULD_BLOCK;
          end else begin
            for (i = 0; i < cnt; i++) ring[(wr_pos + i) % cap] = wdata[8*i +: 8];
            wr_pos = (wr_pos + cnt) % cap;
            held  += cnt;
          end
        end
        OP_READ: begin
          if (cnt > ACCESS_BYTES_DEF || cnt > cap) begin
            r.status = STS_TOO_LARGE;
          end else if (held < cnt) begin
            if (closed) begin
              r.status = STS_READ_CLOSED;
              read_ok  = 1'b0;
            end else begin
              r.status = STS_WOULD_BLOCK;
            end
          end else begin
            for (i = 0; i < cnt; i++) r.read_data[8*i +: 8] = ring[(rd_pos + i) % cap];
            rd_pos = (rd_pos + cnt) % cap;
            held  -= cnt;
          end
        end
        OP_CLOSE: closed = 1'b1;
        default: ;
      endcase
      r.read_ok = read_ok;
      r.fill    = cap_t'(held);
      pending_replies.push_back(r);
    endfunction

    task flag_mismatch(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    task check_result(status_t status, data_t read_data, logic read_ok_flag, cap_t fill);
      reply_t want;
      if (pending_replies.size() == 0) begin
        flag_mismatch("result word with no request waiting");
        return;
      end
      want = pending_replies.pop_front();
      if (status !== want.status)
        flag_mismatch($sformatf("status %0d, expected %0d", status, want.status));
      if (read_data !== want.read_data)
        flag_mismatch($sformatf("read_data %h, expected %h", read_data, want.read_data));
      if (read_ok_flag !== want.read_ok)
        flag_mismatch($sformatf("read_ok_flag %b, expected %b", read_ok_flag, want.read_ok));
      if (fill !== want.fill)
        flag_mismatch($sformatf("fill_level %0d, expected %0d", fill, want.fill));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  cap_t cfg_wdata_i;

  crbc_in_if  req_if ();
  crbc_out_if res_if ();

  closable_byte_ring_channel u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (req_if),
    .out_o       (res_if)
  );

  ring_channel_checker scb = new();

  int burst_left   = 0;
  bit hold_request = 1'b0;
  int idle_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      scb.check_result(res_if.status, res_if.read_data, res_if.read_ok_flag,
                       res_if.fill_level);
  end

  // Ends the run when neither side has moved a word for too long.
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: the stall pattern changes after each random span, and one long hold
  // lets the channel back up into its input.
  initial begin : result_sink
    int mode;
    int span;
    int hold_left;
    hold_left    = 0;
    res_if.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(32, 256);
      repeat (span) begin
        @(negedge clk_i);
        if (hold_request) begin
          hold_request = 1'b0;
          hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
          hold_left--;
          res_if.ready <= 1'b0;
        end else begin
          case (mode)
            0: res_if.ready <= 1'b1;
            1: res_if.ready <= ($urandom_range(0, 9) < 7);
            2: res_if.ready <= ($urandom_range(0, 9) < 3);
            default: res_if.ready <= ~res_if.ready;
          endcase
        end
      end
    end
  end

  task automatic send_request(op_t op, count_t cnt, data_t wdata);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        @(negedge clk_i);
        req_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    req_if.valid      <= 1'b1;
    req_if.op         <= op;
    req_if.byte_count <= cnt;
    req_if.write_data <= wdata;
    do @(posedge clk_i); while (!(req_if.valid && req_if.ready));
    burst_left--;
    scb.accept_request(op, cnt, wdata);
  endtask

  task automatic wait_drained();
    while (scb.pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // The register is only written with no request in work.
  task automatic write_capacity(cap_t value);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_DELAY) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    scb.set_capacity(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly in-range reads and writes; a few words carry odd counts or odd op codes.
  task automatic send_random(int write_pct, bit any_op);
    op_t         op;
    count_t      cnt;
    int unsigned cap;
    int unsigned top;
    cap = scb.eff_capacity();
    top = (cap < ACCESS_BYTES_DEF) ? cap : ACCESS_BYTES_DEF;
    if ($urandom_range(0, 99) < 7) begin
      op  = any_op ? op_t'($urandom_range(0, 3)) : ($urandom_range(0, 2) == 0 ? OP_UNUSED :
            ($urandom_range(0, 1) ? OP_WRITE : OP_READ));
      cnt = count_t'($urandom_range(0, 15));
    end else begin
      op  = ($urandom_range(0, 99) < write_pct) ? OP_WRITE : OP_READ;
      cnt = count_t'($urandom_range(1, top));
    end
    send_request(op, cnt, {$urandom, $urandom});
  endtask

  task automatic run_phase(cap_t cap_value, int n, int write_pct, bit any_op);
    write_capacity(cap_value);
    repeat (n) send_random(write_pct, any_op);
  endtask

  initial begin : stimulus
    rst_ni            = 1'b0;
    cfg_we_i          = 1'b0;
    cfg_wdata_i       = '0;
    req_if.valid      = 1'b0;
    req_if.op         = OP_WRITE;
    req_if.byte_count = '0;
    req_if.write_data = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero counts, an empty read, full-width extremes, oversize counts and the spare op code.
    send_request(OP_WRITE, 4'd0, '1);
    send_request(OP_READ, 4'd0, '0);
    send_request(OP_READ, 4'd1, '0);
    send_request(OP_WRITE, 4'd8, '1);
    send_request(OP_WRITE, 4'd8, '0);
    send_request(OP_WRITE, 4'd3, 64'h0123_4567_89ab_cdef);
    send_request(OP_READ, 4'd8, '0);
    send_request(OP_READ, 4'd8, '1);
    send_request(OP_READ, 4'd3, '0);
    send_request(OP_WRITE, 4'd9, '1);
    send_request(OP_READ, 4'd15, '0);
    send_request(OP_UNUSED, 4'd15, '1);

    run_phase(9'd0, 40, 50, 1'b0);
    run_phase(9'd1, 40, 50, 1'b0);
    // The long hold starts only once the requests of this phase are being offered.
    write_capacity(9'd511);
    hold_request = 1'b1;
    repeat (200) send_random(70, 1'b0);
    run_phase(9'd256, 50, 35, 1'b0);
    run_phase(9'd5, 120, 50, 1'b0);
    run_phase(9'd8, 120, 55, 1'b0);
    run_phase(9'd13, 150, 50, 1'b0);
    run_phase(cap_t'($urandom_range(2, 255)), 150, 55, 1'b0);
    run_phase(cap_t'($urandom_range(2, 255)), 150, 45, 1'b0);

    // Close with bytes still held: reads drain them, then a short read fails for good.
    write_capacity(9'd16);
    send_request(OP_WRITE, 4'd8, {$urandom, $urandom});
    send_request(OP_WRITE, 4'd8, {$urandom, $urandom});
    send_request(OP_WRITE, 4'd1, '1);
    send_request(OP_READ, 4'd3, '0);
    send_request(OP_CLOSE, 4'd0, '0);
    send_request(OP_WRITE, 4'd2, '1);
    send_request(OP_WRITE, 4'd0, '1);
    send_request(OP_WRITE, 4'd9, '1);
    send_request(OP_READ, 4'd8, '0);
    send_request(OP_READ, 4'd5, '0);
    send_request(OP_READ, 4'd8, '0);
    send_request(OP_READ, 4'd0, '0);
    send_request(OP_READ, 4'd9, '0);
    send_request(OP_CLOSE, 4'd3, '1);
    send_request(OP_UNUSED, 4'd0, '0);
    repeat (60) send_random(50, 1'b1);
    run_phase(9'd9, 20, 50, 1'b1);

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    wait_drained();
    repeat (30) @(posedge clk_i);
    if (scb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
